// ===== hw/rtl/jse_pkg.sv =====
// Shared types, codes and lookup functions for the JSON string escaper.
package jse_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned IDX_W  = 3;

    // Kind of work handed from the front to the back
    localparam logic [KIND_W-1:0] K_PLAIN     = 3'd0;
    localparam logic [KIND_W-1:0] K_PAIR      = 3'd1;
    localparam logic [KIND_W-1:0] K_UNI       = 3'd2;
    localparam logic [KIND_W-1:0] K_DONE_OK   = 3'd3;
    localparam logic [KIND_W-1:0] K_DONE_FAIL = 3'd4;

    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_TOP  = 8'h20;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              store;
        logic              run_last;
        logic              string_done;
        logic              ok;
        logic [LEN_W-1:0]  out_length;
    } t_result;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] r;
        if (nib < 4'd10) r = 8'h30 + {4'b0, nib};
        else             r = 8'h37 + {4'b0, nib};
        return r;
    endfunction

    // Second character of a two-character escape, zero when none applies
    function automatic logic [BYTE_W-1:0] short_escape(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        unique case (c)
            8'h08:     r = 8'h62; // b
            8'h0C:     r = 8'h66; // f
            8'h0A:     r = 8'h6E; // n
            8'h0D:     r = 8'h72; // r
            8'h09:     r = 8'h74; // t
            CH_QUOTE:  r = CH_QUOTE;
            CH_BSLASH: r = CH_BSLASH;
            default:   r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/jse_front.sv =====
// Front end: takes input beats, sizes each escape, checks room and queues work.
module jse_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [jse_pkg::LEN_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [jse_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                        o_push,
    output jse_pkg::t_entry             o_entry,
    input  logic                        i_q_ready
);

    logic [jse_pkg::LEN_W-1:0] r_capacity, n_capacity;
    logic [jse_pkg::LEN_W-1:0] r_used, n_used;
    logic                      r_ovf, n_ovf;

    logic                        accept;
    logic                        is_end;
    logic [jse_pkg::BYTE_W-1:0]  esc;
    logic [2:0]                  enc_len;
    logic [jse_pkg::LEN_W+1:0]   need;
    logic                        fits;
    logic                        good;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign is_end     = (i_in_byte == jse_pkg::CH_NUL);
    assign esc        = jse_pkg::short_escape(i_in_byte);

    always_comb begin
        o_entry.data = i_in_byte;
        o_entry.len  = '0;
        if (esc != jse_pkg::CH_NUL) begin
            o_entry.kind = jse_pkg::K_PAIR;
            o_entry.data = esc;
            enc_len      = 3'd2;
        end else if (i_in_byte < jse_pkg::CTRL_TOP) begin
            o_entry.kind = jse_pkg::K_UNI;
            enc_len      = 3'd6;
        end else begin
            o_entry.kind = jse_pkg::K_PLAIN;
            enc_len      = 3'd1;
        end
        good = !r_ovf && (r_used < r_capacity);
        if (is_end) begin
            o_entry.data = jse_pkg::CH_NUL;
            o_entry.kind = good ? jse_pkg::K_DONE_OK : jse_pkg::K_DONE_FAIL;
            o_entry.len  = good ? r_used : '0;
        end
    end

    // Escape fits when used + len + 1 (the NUL) stays within capacity
    assign need = {2'b0, r_used} + {{(jse_pkg::LEN_W-1){1'b0}}, enc_len} + 18'd1;
    assign fits = need <= {2'b0, r_capacity};

    assign o_push = accept && (is_end || (!r_ovf && fits));

    always_comb begin
        n_capacity = i_cfg_wr_en ? i_cfg_wr_data : r_capacity;
        n_used     = r_used;
        n_ovf      = r_ovf;
        if (accept) begin
            if (is_end) begin
                n_used = '0;
                n_ovf  = 1'b0;
            end else if (!r_ovf) begin
                if (fits) n_used = r_used + {{(jse_pkg::LEN_W-3){1'b0}}, enc_len};
                else      n_ovf  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'd256;
            r_used     <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_capacity <= n_capacity;
            r_used     <= n_used;
            r_ovf      <= n_ovf;
        end
    end

endmodule

// ===== hw/rtl/jse_queue.sv =====
// Short FIFO of work entries between the front and the back.
module jse_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jse_pkg::t_entry i_entry,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output jse_pkg::t_entry o_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    jse_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/jse_back.sv =====
// Back end: expands queued entries into output beats through an output register.
module jse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  jse_pkg::t_entry  i_entry,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output jse_pkg::t_result o_result
);

    logic [jse_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_valid, n_valid;
    jse_pkg::t_result          r_res;
    jse_pkg::t_result          nxt;
    logic [jse_pkg::IDX_W-1:0] last_idx;
    logic                      load;

    assign load = i_q_valid && (!r_valid || i_out_ready);

    always_comb begin
        nxt.out_byte    = i_entry.data;
        nxt.store       = 1'b1;
        nxt.string_done = 1'b0;
        nxt.ok          = 1'b0;
        nxt.out_length  = '0;
        last_idx        = 3'd0;
        unique case (i_entry.kind)
            jse_pkg::K_PAIR: begin
                last_idx = 3'd1;
                if (r_idx == 3'd0) nxt.out_byte = jse_pkg::CH_BSLASH;
            end
            jse_pkg::K_UNI: begin
                last_idx = 3'd5;
                case (r_idx)
                    3'd0:    nxt.out_byte = jse_pkg::CH_BSLASH;
                    3'd1:    nxt.out_byte = jse_pkg::CH_U;
                    3'd2:    nxt.out_byte = jse_pkg::CH_ZERO;
                    3'd3:    nxt.out_byte = jse_pkg::CH_ZERO;
                    3'd4:    nxt.out_byte = jse_pkg::hex_digit(i_entry.data[7:4]);
                    default: nxt.out_byte = jse_pkg::hex_digit(i_entry.data[3:0]);
                endcase
            end
            jse_pkg::K_DONE_OK: begin
                nxt.string_done = 1'b1;
                nxt.ok          = 1'b1;
                nxt.out_length  = i_entry.len;
            end
            jse_pkg::K_DONE_FAIL: begin
                nxt.store       = 1'b0;
                nxt.string_done = 1'b1;
            end
            default: ;
        endcase
        nxt.run_last = (r_idx == last_idx);
    end

    assign o_pop = load && (r_idx == last_idx);

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = (r_idx == last_idx) ? '0 : r_idx + 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_res <= nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_res;

endmodule

// ===== hw/rtl/json_string_escaper.sv =====
// Top level of the JSON string escaper.
// Takes a string one byte per input beat and gives its JSON-escaped form one
// byte per output beat; a zero byte closes the string with a NUL beat that
// carries the length and status, after which the byte count starts afresh.
// Plain bytes sustain one input beat per cycle while the queue has room. An
// escaped byte gives two or six output beats, one per cycle while the
// receiver is ready. Bytes pass a QUEUE_DEPTH-entry work queue, then the
// output register; the input stalls only when the queue fills. Write the
// capacity register only while no string bytes are in flight.
module json_string_escaper #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_store,
    output logic        o_run_last,
    output logic        o_string_done,
    output logic        o_ok,
    output logic [15:0] o_out_length
);

    logic             push, q_ready, q_valid, pop;
    jse_pkg::t_entry  push_entry, head_entry;
    jse_pkg::t_result result;

    jse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_push        (push),
        .o_entry       (push_entry),
        .i_q_ready     (q_ready)
    );

    jse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    jse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_out_byte    = result.out_byte;
    assign o_store       = result.store;
    assign o_run_last    = result.run_last;
    assign o_string_done = result.string_done;
    assign o_ok          = result.ok;
    assign o_out_length  = result.out_length;

endmodule

// ===== tb/sv/json_string_escaper_tb.sv =====
// Self-checking testbench for json_string_escaper: random strings against a built-in escaping model.
module json_string_escaper_tb;

    localparam int unsigned CLK_PERIOD = 12;
    localparam int unsigned HOLD_OFF   = 60;
    // Queue drain plus output register; covers bytes that give no beat
    localparam int unsigned DRAIN_WAIT = 16;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = 16'd0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_in_byte     = 8'd0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_store;
    logic        o_run_last;
    logic        o_string_done;
    logic        o_ok;
    logic [15:0] o_out_length;

    json_string_escaper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_store       (o_store),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done),
        .o_ok          (o_ok),
        .o_out_length  (o_out_length)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Model state
    logic [15:0] capacity_mdl;
    logic [15:0] used_mdl;
    logic        overflow_mdl;

    logic [7:0]       pending_bytes [$];
    jse_pkg::t_result escaped_q [$];

    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 48;
    int unsigned stall_req     = 0;
    int unsigned stall_seen    = 0;
    int unsigned hold_left     = 0;
    bit          in_beat       = 1'b0;

    int unsigned mismatch_cnt    = 0;
    int unsigned bytes_in        = 0;
    int unsigned productive_in   = 0;
    int unsigned out_beats       = 0;
    int unsigned strings_ok      = 0;
    int unsigned strings_failed  = 0;
    int unsigned in_stall_cycles = 0;
    int unsigned cap_writes      = 0;

    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
    endfunction

    // Works out the beats one accepted byte gives and advances the model
    task automatic escape_char(input logic [7:0] c);
        logic [7:0]       seq [6];
        int unsigned      n;
        int unsigned      room;
        jse_pkg::t_result r;
        n = 1;
        seq[0] = c;
        if (c == jse_pkg::CH_NUL) begin
            if (!overflow_mdl && used_mdl < capacity_mdl)
                r = '{jse_pkg::CH_NUL, 1'b1, 1'b1, 1'b1, 1'b1, used_mdl};
            else
                r = '{jse_pkg::CH_NUL, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0};
            escaped_q.push_back(r);
            productive_in++;
            used_mdl = 16'd0;
            overflow_mdl = 1'b0;
            return;
        end
        if (overflow_mdl)
            return;
        if (c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH) begin
            seq[0] = jse_pkg::CH_BSLASH;
            seq[1] = c;
            n = 2;
        end else if (c == 8'h08 || c == 8'h0C || c == 8'h0A || c == 8'h0D || c == 8'h09) begin
            seq[0] = jse_pkg::CH_BSLASH;
            case (c)
                8'h08:   seq[1] = "b";
                8'h0C:   seq[1] = "f";
                8'h0A:   seq[1] = "n";
                8'h0D:   seq[1] = "r";
                default: seq[1] = "t";
            endcase
            n = 2;
        end else if (c < jse_pkg::CTRL_TOP) begin
            seq[0] = jse_pkg::CH_BSLASH;
            seq[1] = jse_pkg::CH_U;
            seq[2] = jse_pkg::CH_ZERO;
            seq[3] = jse_pkg::CH_ZERO;
            seq[4] = nibble_to_ascii(c[7:4]);
            seq[5] = nibble_to_ascii(c[3:0]);
            n = 6;
        end
        if (int'(used_mdl) + 1 <= int'(capacity_mdl))
            room = int'(capacity_mdl) - int'(used_mdl) - 1;
        else
            room = 0;
        if (n > room) begin
            overflow_mdl = 1'b1;
            return;
        end
        for (int i = 0; i < n; i++) begin
            r = '{seq[i], 1'b1, (i + 1 == n), 1'b0, 1'b0, 16'd0};
            escaped_q.push_back(r);
        end
        used_mdl = used_mdl + 16'(n);
        productive_in++;
    endtask

    // Sender: holds a beat until taken, then offers the next or idles
    always @(negedge i_clk) begin
        if (i_in_valid && !in_beat) begin
            // payload held
        end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            i_in_valid <= 1'b1;
            i_in_byte  <= pending_bytes.pop_front();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen  <= stall_req;
            hold_left   <= HOLD_OFF;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        jse_pkg::t_result got;
        jse_pkg::t_result want;
        in_beat = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_byte, o_store, o_run_last, o_string_done, o_ok, o_out_length};
            out_beats++;
            if (escaped_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: byte %h store %b last %b done %b ok %b len %0d",
                             got.out_byte, got.store, got.run_last, got.string_done,
                             got.ok, got.out_length);
            end else begin
                want = escaped_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch: exp byte %h store %b last %b done %b ok %b len %0d",
                                  " | got byte %h store %b last %b done %b ok %b len %0d"},
                                 want.out_byte, want.store, want.run_last, want.string_done,
                                 want.ok, want.out_length,
                                 got.out_byte, got.store, got.run_last, got.string_done,
                                 got.ok, got.out_length);
                end
            end
            if (got.string_done === 1'b1) begin
                if (got.ok === 1'b1) strings_ok++;
                else                 strings_failed++;
            end
        end
        if (i_rst_n && i_in_valid && !o_in_ready)
            in_stall_cycles++;
        if (in_beat) begin
            bytes_in++;
            escape_char(i_in_byte);
        end
    end

    // Capacity only changes with nothing in flight
    task automatic set_capacity(input logic [15:0] cap);
        @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || escaped_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        capacity_mdl   = cap;
        cap_writes++;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned sel;
        logic [7:0]  c;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
        end else if (sel < 50) begin
            c = $urandom_range(0, 1) ? jse_pkg::CH_QUOTE : jse_pkg::CH_BSLASH;
        end else if (sel < 65) begin
            case ($urandom_range(0, 4))
                0:       c = 8'h08;
                1:       c = 8'h0C;
                2:       c = 8'h0A;
                3:       c = 8'h0D;
                default: c = 8'h09;
            endcase
        end else if (sel < 80) begin
            c = 8'($urandom_range(8'h01, 8'h1F));
        end else begin
            c = 8'($urandom_range(8'h80, 8'hFF));
        end
        return c;
    endfunction

    // Mostly terminated strings; some left open, some raw noise with stray zeros
    task automatic queue_random_text(input int unsigned max_len);
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(0, max_len);
        if (kind == 0) begin
            repeat (len + 1) pending_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (len) pending_bytes.push_back(pick_char());
            if (kind != 1)
                pending_bytes.push_back(jse_pkg::CH_NUL);
        end
    endtask

    // Target is a count of accepted input bytes
    task automatic run_segment(input int unsigned target, input int unsigned max_len);
        int unsigned base;
        base = bytes_in;
        while (bytes_in - base < target) begin
            queue_random_text(max_len);
            wait (pending_bytes.size() == 0);
        end
    endtask

    initial begin
        logic [7:0] directed [$];
        capacity_mdl = 16'd256;
        used_mdl     = 16'd0;
        overflow_mdl = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Every escape class and the byte extremes, at the reset capacity
        directed = {8'h41, jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH, 8'h08, 8'h0C, 8'h0A,
                    8'h0D, 8'h09, 8'h01, 8'h1F, 8'h20, 8'h7F, 8'h80, 8'hFF,
                    jse_pkg::CH_NUL, jse_pkg::CH_NUL};
        foreach (directed[i]) pending_bytes.push_back(directed[i]);

        // No room at all: string fails, empty string too
        set_capacity(16'd0);
        pending_bytes.push_back(8'h61);
        pending_bytes.push_back(jse_pkg::CH_NUL);
        pending_bytes.push_back(jse_pkg::CH_NUL);

        // Room only for the NUL
        set_capacity(16'd1);
        pending_bytes.push_back(jse_pkg::CH_NUL);
        pending_bytes.push_back(8'h61);
        pending_bytes.push_back(jse_pkg::CH_NUL);

        // Unicode escape fills the buffer exactly
        set_capacity(16'd7);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(jse_pkg::CH_NUL);

        // Capacity lowered below the bytes already written mid-string
        pending_bytes.push_back(8'h61);
        pending_bytes.push_back(8'h62);
        pending_bytes.push_back(8'h63);
        set_capacity(16'd2);
        pending_bytes.push_back(8'h64);
        pending_bytes.push_back(jse_pkg::CH_NUL);

        send_idle_pct = 27;
        recv_idle_pct = 48;
        set_capacity(16'd256);
        run_segment(25, 12);
        set_capacity(16'($urandom_range(4, 24)));
        run_segment(20, 12);

        send_idle_pct = 48;
        recv_idle_pct = 27;
        set_capacity(16'hFFFF);
        run_segment(25, 12);
        set_capacity(16'($urandom_range(1, 12)));
        run_segment(20, 8);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_capacity(16'hFFFF);
        // Escape-heavy burst while the receiver holds off: the work queue fills
        repeat (40) pending_bytes.push_back($urandom_range(0, 1) ? 8'h0A : 8'h05);
        pending_bytes.push_back(jse_pkg::CH_NUL);
        stall_req++;
        wait (pending_bytes.size() == 0);
        set_capacity(16'($urandom_range(0, 65535)));
        run_segment(20, 12);
        set_capacity(16'd2);
        run_segment(20, 6);

        wait (pending_bytes.size() == 0 && !i_in_valid);
        wait (escaped_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d input bytes (%0d giving beats), %0d output beats, %0d capacity writes",
                 bytes_in, productive_in, out_beats, cap_writes);
        $display("strings closed ok %0d, over capacity %0d; input stalled %0d cycles",
                 strings_ok, strings_failed, in_stall_cycles);
        if (mismatch_cnt == 0)
            $display("json_string_escaper_tb: PASS");
        else
            $display("json_string_escaper_tb: FAIL");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("json_string_escaper_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_queue.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper.sv
tb/sv/json_string_escaper_tb.sv
